// ===== rtl/sdes_pkg.sv =====
// Shared types, register indexes and constants of the stick dead zone, expo and slew block.
package sdes_pkg;

  // Configuration port geometry and register indexes.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 22;

  localparam logic [CFG_IDX_W-1:0] REG_DZ_HALF        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_GAIN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXPO           = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_RATE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_HOVER = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SLEW_LIMIT     = 3'd5;

  // Register reset values.
  localparam logic [13:0] DZ_HALF_RST        = 14'd1638;
  localparam logic [21:0] SPAN_GAIN_RST      = 22'd18204;
  localparam logic [14:0] EXPO_RST           = 15'd4915;
  localparam logic [15:0] THROTTLE_RATE_RST  = 16'd512;
  localparam logic [7:0]  THROTTLE_HOVER_RST = 8'd128;
  localparam logic [15:0] SLEW_LIMIT_RST     = 16'd2048;

  // Fixed-point constants.
  localparam logic [14:0] Q14_ONE      = 15'd16384;
  localparam logic [15:0] NEUTRAL_Q88  = 16'd32768;
  localparam logic [7:0]  CMD_TOP      = 8'd254;
  localparam logic [7:0]  CMD_MID      = 8'd127;
  localparam logic [7:0]  CMD_NEUTRAL  = 8'd128;
  localparam logic [19:0] SNAP_LIMIT   = 20'd16384;

  // Axis codes.
  localparam logic [1:0] AXIS_ROLL  = 2'd0;
  localparam logic [1:0] AXIS_PITCH = 2'd1;
  localparam logic [1:0] AXIS_YAW   = 2'd2;

  typedef struct packed {
    logic               connected;
    logic [14:0]        trigger_up;
    logic [14:0]        trigger_down;
    logic signed [15:0] roll_in;
    logic signed [15:0] pitch_in;
    logic signed [15:0] yaw_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] roll_out;
    logic [7:0] pitch_out;
    logic [7:0] yaw_out;
    logic [7:0] throttle_out;
    logic       active;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GAIN,
    ST_EXPO,
    ST_CURVE,
    ST_LAST_SLEW,
    ST_DONE
  } state_t;

  // Operand selection of the shared multiplier.
  typedef enum logic [1:0] {
    MUL_THR,
    MUL_GAIN,
    MUL_EXPO,
    MUL_CURVE
  } mul_sel_t;

  typedef struct packed {
    logic       load_in;
    mul_sel_t   mul_sel;
    logic [1:0] mul_axis;
    logic       upd_thr;
    logic       upd_slew;
    logic [1:0] slew_axis;
    logic       load_out;
  } cmd_t;

endpackage

// ===== rtl/stick_deadzone_expo_slew_top.sv =====
// Top level of the gamepad stick shaping block: dead zone, expo curve, slew and throttle.
// A connected sample steps through gain, expo and curve passes for roll, pitch and yaw, then a last
// slew step and a done step that registers its result; the single shared multiplier forms three products
// per axis plus the throttle product. A new sample is taken only in idle; disconnected ones make no result.
// Reset (synchronous, active high) loads the register defaults, puts every kept axis value
// and the throttle level at 128.0, and empties the result register.
module stick_deadzone_expo_slew_top import sdes_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Command bundle from the sequencer to the datapath. The sequencer walks
  // roll, pitch and yaw through three multiplier passes each (gain, expo
  // product, curve product). The slew update of one axis rides along in the
  // cycle that starts the gain pass of the next axis, and the throttle update
  // rides along with the first gain pass.
  cmd_t cmd;

  // Register writes are always taken; software must write only while the block is
  // idle (the block itself does not enforce this), so no hold-off is needed.
  assign cfg_ready = 1'b1;

  sdes_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_connected (in_data.connected),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cmd          (cmd)
  );

  // The datapath holds the configuration registers, the kept Q8.8 axis and
  // throttle values and the result register. The result register lets the
  // next request enter while a finished result still waits downstream; the
  // sequencer only holds in its last step if that result is still unread.
  sdes_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/sdes_ctrl.sv =====
// Sequencer that steps one sample through the shared multiplier and drives the datapath.
module sdes_ctrl import sdes_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_connected,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  state_t     state;
  state_t     state_next;
  logic [1:0] axis;
  logic [1:0] axis_next;
  logic       out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      axis      <= AXIS_ROLL;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      axis      <= axis_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    axis_next  = axis;
    unique case (state)
      ST_IDLE: begin
        axis_next = AXIS_ROLL;
        if (in_valid && in_connected) begin
          state_next = ST_GAIN;
        end
      end
      ST_GAIN:  state_next = ST_EXPO;
      ST_EXPO:  state_next = ST_CURVE;
      ST_CURVE: begin
        if (axis == AXIS_YAW) begin
          state_next = ST_LAST_SLEW;
        end else begin
          state_next = ST_GAIN;
          axis_next  = axis + 2'd1;
        end
      end
      ST_LAST_SLEW: state_next = ST_DONE;
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.mul_sel   = MUL_THR;
    cmd.mul_axis  = axis;
    cmd.slew_axis = axis - 2'd1;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      ST_GAIN: begin
        cmd.mul_sel = MUL_GAIN;
        if (axis == AXIS_ROLL) begin
          cmd.upd_thr = 1'b1;
        end else begin
          cmd.upd_slew = 1'b1;
        end
      end
      ST_EXPO:  cmd.mul_sel = MUL_EXPO;
      ST_CURVE: cmd.mul_sel = MUL_CURVE;
      ST_LAST_SLEW: begin
        cmd.upd_slew  = 1'b1;
        cmd.slew_axis = AXIS_YAW;
      end
      ST_DONE: cmd.load_out = !out_valid || out_ready;
      default: cmd.load_out = 1'b0;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

// ===== rtl/sdes_dpath.sv =====
// Datapath: configuration registers, shared multiplier, axis curve, slew and throttle state.
module sdes_dpath import sdes_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  input  in_item_t              in_data,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output out_item_t             out_data
);

  function automatic logic [15:0] mag16(input logic signed [15:0] v);
    logic [15:0] u;
    u = v;
    return v[15] ? (~u + 16'd1) : u;
  endfunction

  // Configuration registers.
  logic [13:0] dz_half;
  logic [21:0] span_gain;
  logic [14:0] expo;
  logic [15:0] throttle_rate;
  logic [7:0]  throttle_hover;
  logic [15:0] slew_limit;

  // Kept state.
  logic [15:0] throttle_level;
  logic [15:0] roll_now;
  logic [15:0] pitch_now;
  logic [15:0] yaw_now;

  // Latched sample and working registers.
  logic signed [15:0] r_hold;
  logic signed [15:0] roll_hold;
  logic signed [15:0] pitch_hold;
  logic signed [15:0] yaw_hold;
  logic [50:0]        prod;
  logic [14:0]        s_hold;

  logic signed [15:0] r_port;
  logic [15:0]        r_port_mag;
  logic [21:0]        op_a;
  logic [28:0]        op_b;
  logic signed [15:0] ax_mul;
  logic [15:0]        diff_mul;
  logic [14:0]        s_val;
  logic [14:0]        expo_eff;
  logic [28:0]        blend;

  logic signed [15:0] ax_slew;
  logic [15:0]        mag_slew;
  logic               dead_slew;
  logic               pos_slew;
  logic [14:0]        t_val;
  logic [21:0]        m_val;
  logic [21:0]        m_up;
  logic [7:0]         target;
  logic [15:0]        now_sel;
  logic signed [17:0] d_raw;
  logic signed [17:0] d_lim;
  logic signed [17:0] d_clamp;
  logic [17:0]        now_sum;
  logic [15:0]        now_new;

  logic [15:0]        r_mag;
  logic [19:0]        r_x20;
  logic               thr_big;
  logic [31:0]        q_up;
  logic [17:0]        q_mag;
  logic signed [19:0] lv;
  logic [7:0]         hover_eff;
  logic [15:0]        level_next;

  assign r_port     = signed'({1'b0, in_data.trigger_up}) - signed'({1'b0, in_data.trigger_down});
  assign r_port_mag = mag16(r_port);

  always_comb begin
    case (cmd.mul_axis)
      AXIS_ROLL:  ax_mul = roll_hold;
      AXIS_PITCH: ax_mul = pitch_hold;
      default:    ax_mul = yaw_hold;
    endcase
    case (cmd.slew_axis)
      AXIS_ROLL:  begin ax_slew = roll_hold;  now_sel = roll_now;  end
      AXIS_PITCH: begin ax_slew = pitch_hold; now_sel = pitch_now; end
      default:    begin ax_slew = yaw_hold;   now_sel = yaw_now;   end
    endcase
  end

  // Multiplier operands.
  assign diff_mul = mag16(ax_mul) - {2'b00, dz_half};
  assign s_val    = (prod[50:14] > {22'd0, Q14_ONE}) ? Q14_ONE : prod[28:14];
  assign expo_eff = (expo > Q14_ONE) ? Q14_ONE : expo;
  assign blend    = {Q14_ONE - expo_eff, 14'd0} + prod[28:0];

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_THR: begin
        op_a = {6'd0, r_port_mag};
        op_b = {13'd0, throttle_rate};
      end
      MUL_GAIN: begin
        op_a = span_gain;
        op_b = {13'd0, diff_mul};
      end
      MUL_EXPO: begin
        op_a = {7'd0, expo_eff};
        op_b = {14'd0, s_val};
      end
      MUL_CURVE: begin
        op_a = {7'd0, s_hold};
        op_b = blend;
      end
    endcase
  end

  // Axis target and slew.
  assign mag_slew  = mag16(ax_slew);
  assign dead_slew = mag_slew < {2'b00, dz_half};
  assign pos_slew  = !ax_slew[15] && (ax_slew != 16'sd0);
  assign t_val     = prod[42:28];
  assign m_val     = {t_val, 7'd0} - {7'd0, t_val};
  assign m_up      = m_val + 22'd16383;

  always_comb begin
    if (dead_slew) begin
      target = CMD_NEUTRAL;
    end else if (pos_slew) begin
      target = CMD_MID + m_val[21:14];
    end else begin
      target = CMD_MID - m_up[21:14];
    end
  end

  assign d_raw = signed'({2'b00, target, 8'd0}) - signed'({2'b00, now_sel});
  assign d_lim = signed'({2'b00, slew_limit});

  always_comb begin
    if (d_raw > d_lim) begin
      d_clamp = d_lim;
    end else if (d_raw < -d_lim) begin
      d_clamp = -d_lim;
    end else begin
      d_clamp = d_raw;
    end
  end

  assign now_sum = {2'b00, now_sel} + d_clamp;
  assign now_new = now_sum[15:0];

  // Throttle integration.
  assign r_mag     = mag16(r_hold);
  assign r_x20     = {r_mag, 4'd0} + {2'b00, r_mag, 2'd0};
  assign thr_big   = r_x20 > SNAP_LIMIT;
  assign q_up      = prod[31:0] + 32'd16383;
  assign q_mag     = r_hold[15] ? q_up[31:14] : {1'b0, prod[30:14]};
  assign hover_eff = (throttle_hover > CMD_TOP) ? CMD_TOP : throttle_hover;
  assign lv        = r_hold[15] ? signed'({4'd0, throttle_level}) - signed'({2'b00, q_mag})
                                : signed'({4'd0, throttle_level}) + signed'({2'b00, q_mag});

  always_comb begin
    if (!thr_big) begin
      level_next = {hover_eff, 8'd0};
    end else if (lv < 20'sd0) begin
      level_next = 16'd0;
    end else if (lv > signed'({4'd0, CMD_TOP, 8'd0})) begin
      level_next = {CMD_TOP, 8'd0};
    end else begin
      level_next = lv[15:0];
    end
  end

  // Control and kept state.
  always_ff @(posedge clk) begin
    if (rst) begin
      dz_half        <= DZ_HALF_RST;
      span_gain      <= SPAN_GAIN_RST;
      expo           <= EXPO_RST;
      throttle_rate  <= THROTTLE_RATE_RST;
      throttle_hover <= THROTTLE_HOVER_RST;
      slew_limit     <= SLEW_LIMIT_RST;
      throttle_level <= NEUTRAL_Q88;
      roll_now       <= NEUTRAL_Q88;
      pitch_now      <= NEUTRAL_Q88;
      yaw_now        <= NEUTRAL_Q88;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_DZ_HALF:        dz_half        <= cfg_data[13:0];
          REG_SPAN_GAIN:      span_gain      <= cfg_data[21:0];
          REG_EXPO:           expo           <= cfg_data[14:0];
          REG_THROTTLE_RATE:  throttle_rate  <= cfg_data[15:0];
          REG_THROTTLE_HOVER: throttle_hover <= cfg_data[7:0];
          REG_SLEW_LIMIT:     slew_limit     <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (cmd.upd_thr) begin
        throttle_level <= level_next;
      end
      if (cmd.upd_slew) begin
        case (cmd.slew_axis)
          AXIS_ROLL:  roll_now  <= now_new;
          AXIS_PITCH: pitch_now <= now_new;
          default:    yaw_now   <= now_new;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    prod <= 51'(op_a) * 51'(op_b);
    if (cmd.mul_sel == MUL_EXPO) begin
      s_hold <= s_val;
    end
    if (cmd.load_in) begin
      r_hold     <= r_port;
      roll_hold  <= in_data.roll_in;
      pitch_hold <= in_data.pitch_in;
      yaw_hold   <= in_data.yaw_in;
    end
    if (cmd.load_out) begin
      out_data.roll_out     <= roll_now[15:8];
      out_data.pitch_out    <= pitch_now[15:8];
      out_data.yaw_out      <= yaw_now[15:8];
      out_data.throttle_out <= throttle_level[15:8];
      out_data.active       <= 1'b1;
    end
  end

endmodule

// ===== tb/sv/stick_deadzone_expo_slew_top_test.sv =====
// Self-checking testbench of the stick dead zone, expo, slew and throttle block.
module stick_deadzone_expo_slew_top_test import sdes_pkg::*;;

  // The block has no result for a disconnected sample, so after the last command
  // set has arrived we still let the longest pipeline latency pass before touching
  // the registers or ending the run.
  localparam int SETTLE_CYCLES = 16;
  localparam int RUN_LIMIT = 8_000_000;

  // Indexes past the last register; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  // One full register setting, kept at port width so that junk above a register's
  // own width can be carried to the block.
  typedef struct {
    logic [CFG_DATA_W-1:0] dz_half;
    logic [CFG_DATA_W-1:0] span_gain;
    logic [CFG_DATA_W-1:0] expo;
    logic [CFG_DATA_W-1:0] rate;
    logic [CFG_DATA_W-1:0] hover;
    logic [CFG_DATA_W-1:0] slew;
  } setting_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Our own copy of the block's registers and kept values.
  logic [13:0] dz_r;
  logic [21:0] gain_r;
  logic [14:0] expo_r;
  logic [15:0] rate_r;
  logic [7:0]  hover_r;
  logic [15:0] slew_r;
  logic [15:0] level_q;
  logic [15:0] roll_q;
  logic [15:0] pitch_q;
  logic [15:0] yaw_q;

  // Command sets still owed by the block, oldest first.
  out_item_t expected_cmds[$];

  // Accepted request counts; the sending tasks wait on these.
  int unsigned in_seen = 0;
  int unsigned cfg_seen = 0;
  int unsigned cmd_errors = 0;
  int ready_left = 0;

  stick_deadzone_expo_slew_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A watchdog well beyond the slowest legal run: every gap and stall at its longest.
  initial begin
    #RUN_LIMIT;
    $display("FAILURE");
    $finish;
  end

  // Most idle gaps are short; a few are long enough to let the pipeline run dry.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Dead zone, rescale, expo and map of one stick axis onto 0..254.
  function automatic int shape_axis(input logic signed [15:0] v);
    longint unsigned mag, s, e, blend, t, m;
    int vi;
    vi = int'(v);
    mag = (vi < 0) ? longint'(-vi) : longint'(vi);
    if (mag < dz_r) return 128;
    s = ((mag - dz_r) * gain_r) >> 14;
    if (s > Q14_ONE) s = Q14_ONE;
    // Blend factors above one behave as one.
    e = (expo_r > Q14_ONE) ? Q14_ONE : expo_r;
    blend = (Q14_ONE - e) * Q14_ONE + e * s;
    t = (s * blend) >> 28;
    m = 127 * t;
    // With no dead zone, a zero stick lands here too, on the negative side, and maps to 127.
    if (vi > 0) return 127 + int'(m >> 14);
    return 127 - int'((m + Q14_ONE - 1) >> 14);
  endfunction

  // Move a kept Q8.8 axis value toward its target by at most the slew limit.
  function automatic logic [15:0] slew_toward(input int target, input logic [15:0] now);
    int d, lim;
    d = target * 256 - int'(now);
    lim = int'(slew_r);
    if (d > lim) d = lim;
    if (d < -lim) d = -lim;
    return 16'(int'(now) + d);
  endfunction

  // Next command set of a connected sample; updates the kept values as the block does.
  function automatic out_item_t predict_command(input in_item_t it);
    int r, ra;
    longint p, lv;
    out_item_t res;
    r = int'(it.trigger_up) - int'(it.trigger_down);
    ra = (r < 0) ? -r : r;
    if (ra * 20 > int'(Q14_ONE)) begin
      p = longint'(r) * longint'(rate_r);
      lv = longint'(level_q) + (p >>> 14);
      if (lv < 0) lv = 0;
      if (lv > 254 * 256) lv = 254 * 256;
      level_q = 16'(lv);
    end else begin
      // Centered triggers snap to hover; a hover of 255 is held at the top command.
      level_q = {(hover_r > CMD_TOP) ? CMD_TOP : hover_r, 8'h00};
    end
    roll_q = slew_toward(shape_axis(it.roll_in), roll_q);
    pitch_q = slew_toward(shape_axis(it.pitch_in), pitch_q);
    yaw_q = slew_toward(shape_axis(it.yaw_in), yaw_q);
    res.roll_out = roll_q[15:8];
    res.pitch_out = pitch_q[15:8];
    res.yaw_out = yaw_q[15:8];
    res.throttle_out = level_q[15:8];
    res.active = 1'b1;
    return res;
  endfunction

  // Everything is sampled at the clock edge from values driven after the previous
  // edge, so this block sees the same requests the block does. Register writes and
  // samples are folded into the copy in the order they are accepted, and each
  // accepted command set is checked against the oldest one owed.
  always @(posedge clk) begin : check_and_predict
    out_item_t want;
    if (rst) begin
      dz_r = DZ_HALF_RST;
      gain_r = SPAN_GAIN_RST;
      expo_r = EXPO_RST;
      rate_r = THROTTLE_RATE_RST;
      hover_r = THROTTLE_HOVER_RST;
      slew_r = SLEW_LIMIT_RST;
      level_q = NEUTRAL_Q88;
      roll_q = NEUTRAL_Q88;
      pitch_q = NEUTRAL_Q88;
      yaw_q = NEUTRAL_Q88;
      expected_cmds.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_cmds.size() == 0) begin
          cmd_errors++;
          if (cmd_errors <= 10)
            $display("unexpected command set: roll %0d pitch %0d yaw %0d throttle %0d",
                     out_data.roll_out, out_data.pitch_out, out_data.yaw_out,
                     out_data.throttle_out);
        end else begin
          want = expected_cmds.pop_front();
          if (out_data.roll_out !== want.roll_out || out_data.pitch_out !== want.pitch_out ||
              out_data.yaw_out !== want.yaw_out ||
              out_data.throttle_out !== want.throttle_out ||
              out_data.active !== want.active) begin
            cmd_errors++;
            if (cmd_errors <= 10)
              $display("mismatch: expected r%0d p%0d y%0d t%0d a%0b, got r%0d p%0d y%0d t%0d a%0b",
                       want.roll_out, want.pitch_out, want.yaw_out, want.throttle_out,
                       want.active, out_data.roll_out, out_data.pitch_out, out_data.yaw_out,
                       out_data.throttle_out, out_data.active);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DZ_HALF:        dz_r = cfg_data[13:0];
          REG_SPAN_GAIN:      gain_r = cfg_data[21:0];
          REG_EXPO:           expo_r = cfg_data[14:0];
          REG_THROTTLE_RATE:  rate_r = cfg_data[15:0];
          REG_THROTTLE_HOVER: hover_r = cfg_data[7:0];
          REG_SLEW_LIMIT:     slew_r = cfg_data[15:0];
          default: ;
        endcase
        cfg_seen <= cfg_seen + 1;
      end
      if (in_valid && in_ready) begin
        in_seen <= in_seen + 1;
        // A disconnected sample leaves every kept value alone and owes nothing.
        if (in_data.connected)
          expected_cmds.push_back(predict_command(in_data));
      end
    end
  end

  // The receiver alternates runs of ready with stalls of random length.
  always @(posedge clk) begin : drive_out_ready
    int g;
    if (rst) begin
      out_ready <= 1'b0;
      ready_left <= 0;
    end else if (ready_left != 0) begin
      ready_left <= ready_left - 1;
    end else if (!out_ready) begin
      out_ready <= 1'b1;
      ready_left <= $urandom_range(0, 40);
    end else begin
      g = pick_gap();
      if (g > 0) begin
        out_ready <= 1'b0;
        ready_left <= g - 1;
      end else begin
        ready_left <= $urandom_range(0, 10);
      end
    end
  end

  // Offer one sample and hold it until the block takes the request. Valid stays up
  // when the next sample follows with no gap, so back-to-back requests happen.
  task automatic send_sample(input in_item_t it);
    int unsigned n;
    int g;
    n = in_seen;
    in_valid <= 1'b1;
    in_data <= it;
    wait (in_seen != n);
    g = pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    int unsigned n;
    n = cfg_seen;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    wait (cfg_seen != n);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stop sending, wait for every owed command set, then let the pipeline go quiet.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_setting(input setting_t s);
    drain_results();
    write_reg(REG_DZ_HALF, s.dz_half);
    write_reg(REG_SPAN_GAIN, s.span_gain);
    write_reg(REG_EXPO, s.expo);
    write_reg(REG_THROTTLE_RATE, s.rate);
    write_reg(REG_THROTTLE_HOVER, s.hover);
    write_reg(REG_SLEW_LIMIT, s.slew);
  endtask

  function automatic in_item_t make_sample(input logic conn, input int up, input int down,
                                           input int roll, input int pitch, input int yaw);
    in_item_t it;
    it.connected = conn;
    it.trigger_up = 15'(up);
    it.trigger_down = 15'(down);
    it.roll_in = 16'(roll);
    it.pitch_in = 16'(pitch);
    it.yaw_in = 16'(yaw);
    return it;
  endfunction

  // Stick positions: mostly within travel, with rests, full throws, raw 16-bit words
  // and points right at the current dead zone edge.
  function automatic logic [15:0] rand_stick();
    int v;
    case ($urandom_range(0, 9))
      0: v = 0;
      1: v = ($urandom_range(0, 1) != 0) ? 16384 : -16384;
      2: v = int'($urandom_range(0, 65535));
      3: begin
        v = int'(dz_r) + int'($urandom_range(0, 4)) - 2;
        if ($urandom_range(0, 1) != 0) v = -v;
      end
      default: v = int'($urandom_range(0, 32768)) - 16384;
    endcase
    return 16'(v);
  endfunction

  function automatic in_item_t rand_sample();
    in_item_t it;
    int up, down;
    up = $urandom_range(0, 16384);
    down = $urandom_range(0, 16384);
    case ($urandom_range(0, 9))
      6: begin
        up = $urandom_range(0, 32767);
        down = $urandom_range(0, 32767);
      end
      7: begin
        // Near-equal triggers probe the snap threshold from both sides.
        down = up + int'($urandom_range(0, 1800)) - 900;
        if (down < 0) down = 0;
      end
      8: begin
        up = 0;
        down = 0;
      end
      9: begin
        up = ($urandom_range(0, 1) != 0) ? 16384 : 0;
        down = 16384 - up;
      end
      default: ;
    endcase
    it.connected = ($urandom_range(0, 9) != 0);
    it.trigger_up = 15'(up);
    it.trigger_down = 15'(down);
    it.roll_in = rand_stick();
    it.pitch_in = rand_stick();
    it.yaw_in = rand_stick();
    return it;
  endfunction

  // Sometimes set bits above a register's width; the block must ignore them.
  function automatic logic [CFG_DATA_W-1:0] with_junk(input int val, input int w);
    logic [CFG_DATA_W-1:0] junk;
    junk = 22'($urandom) & ~((22'd1 << w) - 22'd1);
    if ($urandom_range(0, 3) != 0) junk = '0;
    return 22'(val) | junk;
  endfunction

  // Register defaults: rest, full throws, dead zone edges, snap threshold, sticks and
  // triggers beyond one, a disconnected sample in the middle of a run.
  task automatic test_default_setting();
    send_sample(make_sample(1'b1, 0, 0, 0, 0, 0));
    send_sample(make_sample(1'b1, 16384, 0, 16384, -16384, 0));
    send_sample(make_sample(1'b1, 0, 16384, -16384, 16384, 16384));
    send_sample(make_sample(1'b1, 0, 0, 1637, -1637, 1638));
    send_sample(make_sample(1'b1, 820, 0, -1638, 1639, -1639));
    send_sample(make_sample(1'b1, 0, 820, 8192, -8192, 100));
    send_sample(make_sample(1'b1, 819, 0, 16384, 16384, 16384));
    send_sample(make_sample(1'b0, 32767, 32767, 32767, 32767, 32767));
    send_sample(make_sample(1'b1, 32767, 0, 32767, -32768, -1));
    send_sample(make_sample(1'b1, 0, 32767, -32768, 32767, 1));
    send_sample(make_sample(1'b1, 16384, 16384, 0, 0, 0));
  endtask

  // Register corners: no dead zone with a resting stick, expo beyond one, hover past
  // the top command, a slew limit that freezes the axes and one that never binds.
  task automatic test_special_settings();
    setting_t dflt;
    dflt = '{22'(DZ_HALF_RST), 22'(SPAN_GAIN_RST), 22'(EXPO_RST),
             22'(THROTTLE_RATE_RST), 22'(THROTTLE_HOVER_RST), 22'(SLEW_LIMIT_RST)};
    drain_results();
    write_reg(REG_DZ_HALF, 22'd0);
    send_sample(make_sample(1'b1, 0, 0, 0, 0, 0));
    send_sample(make_sample(1'b1, 0, 0, 1, -1, 0));
    drain_results();
    write_reg(REG_EXPO, 22'd32767);
    send_sample(make_sample(1'b1, 0, 0, 8192, -8192, 16384));
    drain_results();
    write_reg(REG_THROTTLE_HOVER, 22'd255);
    send_sample(make_sample(1'b1, 100, 100, 0, 0, 0));
    drain_results();
    write_reg(REG_SLEW_LIMIT, 22'd0);
    send_sample(make_sample(1'b1, 16384, 0, 16384, -16384, 16384));
    send_sample(make_sample(1'b1, 0, 16384, -16384, 16384, -16384));
    drain_results();
    write_reg(REG_SLEW_LIMIT, 22'd65535);
    send_sample(make_sample(1'b1, 0, 16384, -16384, 16384, -16384));
    send_sample(make_sample(1'b1, 16384, 0, 16384, -16384, 16384));
    load_setting(dflt);
  endtask

  // A fixed sweep through the extremes of every register, random samples under each.
  task automatic test_setting_sweep();
    setting_t sweep[6];
    sweep[0] = '{22'd0, 22'd16384, 22'd0, 22'd0, 22'd0, 22'd1};
    sweep[1] = '{22'd16383, 22'd4194303, 22'd16384, 22'd65535, 22'd254, 22'd65535};
    sweep[2] = '{22'd0, 22'd4194303, 22'd32767, 22'd65535, 22'd255, 22'd0};
    sweep[3] = '{22'd8192, 22'd32768, 22'd8192, 22'd4096, 22'd100, 22'd256};
    sweep[4] = '{22'd1638, 22'd18204, 22'd4915, 22'd512, 22'd128, 22'd2048};
    sweep[5] = '{22'd100, 22'd16484, 22'd16384, 22'd1, 22'd254, 22'd65535};
    for (int i = 0; i < 6; i++) begin
      load_setting(sweep[i]);
      if (i == 0) begin
        write_reg(REG_SPARE_A, 22'($urandom));
        write_reg(REG_SPARE_B, 22'($urandom));
      end
      repeat (120) send_sample(rand_sample());
    end
  endtask

  // Random settings, mostly the kind software would program, some arbitrary.
  task automatic test_random_settings();
    setting_t s;
    int dz, gain;
    repeat (6) begin
      dz = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 6000) : $urandom_range(0, 16383);
      if ($urandom_range(0, 3) != 0) begin
        gain = (1 << 28) / (16384 - dz);
        if (gain > 4194303) gain = 4194303;
      end else begin
        gain = $urandom_range(16384, 4194303);
      end
      s.dz_half = with_junk(dz, 14);
      s.span_gain = 22'(gain);
      s.expo = with_junk(($urandom_range(0, 3) != 0) ? $urandom_range(0, 16384)
                                                     : $urandom_range(0, 32767), 15);
      s.rate = with_junk($urandom_range(0, 65535), 16);
      s.hover = with_junk($urandom_range(0, 255), 8);
      s.slew = with_junk(($urandom_range(0, 3) != 0) ? $urandom_range(1, 8000)
                                                     : $urandom_range(0, 65535), 16);
      load_setting(s);
      repeat (80) send_sample(rand_sample());
    end
  endtask

  // The sender goes silent until the block has handed back everything it owes.
  task automatic test_paused_sender();
    repeat (3) begin
      repeat (50) send_sample(rand_sample());
      drain_results();
    end
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_setting();
    test_special_settings();
    test_setting_sweep();
    test_random_settings();
    test_paused_sender();
    drain_results();
    if (expected_cmds.size() != 0)
      $display("%0d command sets never arrived", expected_cmds.size());
    if (cmd_errors == 0 && expected_cmds.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
